// ----- rtl/kvgt_pkg.sv -----
package kvgt_pkg;

    typedef enum logic [1:0] {
        EV_START  = 2'd0,
        EV_UPDATE = 2'd1,
        EV_END    = 2'd2
    } t_event_kind;

    localparam logic [2:0] CFG_SOFT_THR  = 3'd0;
    localparam logic [2:0] CFG_HARD_THR  = 3'd1;
    localparam logic [2:0] CFG_ROLL_WIN  = 3'd2;
    localparam logic [2:0] CFG_YAW_WIN   = 3'd3;
    localparam logic [2:0] CFG_DEBOUNCE  = 3'd4;

    localparam logic [1:0] GATE_NONE = 2'd0;
    localparam logic [1:0] GATE_SOFT = 2'd2;
    localparam logic [1:0] GATE_HARD = 2'd3;

    localparam logic [3:0] COUNT_MAX = 4'd15;

    // per-key state word
    typedef struct packed {
        logic        running;
        logic        skipped;
        logic [3:0]  count;
        logic [1:0]  gate;
        logic [4:0]  repeats;
        logic [11:0] peak;
        logic [47:0] rel_time;
    } t_key_state;

    // one result item, packed as on the output bus (event_kind lowest)
    typedef struct packed {
        logic [1:0]         gate_value;
        logic               gate_valid;
        logic signed [12:0] yaw_out;
        logic signed [12:0] roll_out;
        logic [11:0]        pressure_out;
        logic [7:0]         key_out;
        logic [1:0]         event_kind;
    } t_result;

endpackage

// ----- rtl/key_velocity_gate_tracker.sv -----
// Channel   | Dir | Payload
// s_axis    | in  | tdata: time_us[47:0] key_index[55:48] active[56] pressure[68:57]
//           |     |        roll_raw[80:69] yaw_raw[92:81], zero fill to 96
// m_axis    | out | tdata: event_kind[1:0] key_out[9:2] pressure_out[21:10]
//           |     |        roll_out[34:22] yaw_out[47:35] gate_valid[48] gate_value[50:49]
// cfg       | in  | i_cfg_we, i_cfg_index, i_cfg_data (20 bit)
//
// Flow: a start or update result is valid once its item has passed the state
// read, the evaluation, the divide steps and the output stage; the roll and yaw
// dividers run in parallel. A note end is valid after the state read and the
// evaluation; items that give no result go back to idle. A new item is taken
// only once the last one is finished and the result register is free.
// Reset: synchronous, active low; after reset a clearing pass writes every
// state entry, with s_axis_tready low.
// Stalls: the result sits in an output register; the next item is accepted
// only once that register is free.
module key_velocity_gate_tracker #(
    parameter int KEY_COUNT        = 144,
    parameter int ESTIMATE_SAMPLES = 10,
    parameter int GATE_REPEATS     = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // time_us, key_index, active, pressure, roll_raw, yaw_raw
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // event_kind, key_out, pressure_out, roll_out, yaw_out,
                                        // gate_valid, gate_value
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);
    import kvgt_pkg::*;

    localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int SW = $bits(t_key_state);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_EVAL, ST_DIV, ST_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [12:0] r_soft_thr, r_hard_thr, r_roll_win, r_yaw_win;
    logic [19:0] r_debounce;

    // captured item
    logic [47:0] r_time;
    logic [7:0]  r_key;
    logic        r_act;
    logic [11:0] r_press;
    logic [11:0] r_roll_raw, r_yaw_raw;

    logic [AW-1:0] r_clr_addr;

    // result register
    t_result r_res;
    logic    r_res_valid;

    // memory port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_key_state    ram_wdata;
    t_key_state    ram_rdata;
    logic [SW-1:0] ram_rdata_raw;
    logic [AW-1:0] ram_raddr;

    kvgt_ram #(.WIDTH(SW), .DEPTH(KEY_COUNT)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_raw)
    );
    assign ram_rdata = t_key_state'(ram_rdata_raw);
    assign ram_raddr = r_key[AW-1:0];

    // axis normalization: clamp and magnitude, then divide
    logic        n_roll_neg, n_yaw_neg;
    logic [11:0] n_roll_mag, n_yaw_mag;
    logic        r_roll_neg, r_yaw_neg;
    logic        div_start;
    logic        roll_done, yaw_done;
    logic [11:0] roll_quot, yaw_quot;

    function automatic logic [12:0] clamp_mag(input logic [11:0] raw,
                                              input logic [12:0] win);
        logic signed [13:0] d;
        logic [12:0]        m;
        d = 14'sd2047 - $signed({2'b00, raw});
        m = d[13] ? 13'(-d) : 13'(d);
        clamp_mag = (m > win) ? win : m;
    endfunction

    always_comb begin
        logic [12:0] rm, ym;
        rm = clamp_mag(r_roll_raw, r_roll_win);
        ym = clamp_mag(r_yaw_raw, r_yaw_win);
        n_roll_mag = rm[11:0];
        n_yaw_mag  = ym[11:0];
        n_roll_neg = (r_roll_raw > 12'd2047);
        n_yaw_neg  = (r_yaw_raw > 12'd2047);
    end

    kvgt_div u_div_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_mag(n_roll_mag), .i_win(r_roll_win),
        .o_done(roll_done), .o_quot(roll_quot)
    );
    kvgt_div u_div_yaw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_mag(n_yaw_mag), .i_win(r_yaw_win),
        .o_done(yaw_done), .o_quot(yaw_quot)
    );

    // per-key update, evaluated in ST_EVAL
    t_key_state  n_st;
    logic        n_emit;
    logic [1:0]  n_kind;
    logic        n_gv;
    logic [1:0]  n_gval;
    logic [48:0] n_deadline;

    always_comb begin
        logic [11:0] pk;
        n_st       = ram_rdata;
        n_emit     = 1'b0;
        n_kind     = EV_UPDATE;
        n_gv       = 1'b0;
        n_gval     = GATE_NONE;
        pk         = ram_rdata.peak;
        n_deadline = {1'b0, ram_rdata.rel_time} + 49'(r_debounce);
        if (!r_act) begin
            n_emit         = ram_rdata.running;
            n_kind         = EV_END;
            n_st.running   = 1'b0;
            n_st.rel_time  = r_time;
            n_st.count     = '0;
        end else if (ram_rdata.count == '0) begin
            n_st.count = 4'd1;
            if (ram_rdata.rel_time != '0 && {1'b0, r_time} < n_deadline) begin
                n_st.skipped = 1'b1;
            end else begin
                n_st.skipped = 1'b0;
                n_st.running = 1'b1;
                n_st.peak    = '0;
                n_st.gate    = GATE_NONE;
                n_st.repeats = '0;
                n_emit       = 1'b1;
                n_kind       = EV_START;
                n_gv         = 1'b1;
            end
        end else if (!ram_rdata.skipped) begin
            n_emit = 1'b1;
            if (ram_rdata.gate != GATE_NONE && ram_rdata.repeats != '0) begin
                n_st.repeats = ram_rdata.repeats - 5'd1;
                n_gv         = 1'b1;
                n_gval       = ram_rdata.gate;
            end
            if (r_press > pk) pk = r_press;
            n_st.peak = pk;
            if (ram_rdata.count < 4'(ESTIMATE_SAMPLES)) begin
                n_st.count = ram_rdata.count + 4'd1;
            end else begin
                if (ram_rdata.count == 4'(ESTIMATE_SAMPLES) && {1'b0, pk} > r_hard_thr) begin
                    n_st.gate    = GATE_HARD;
                    n_st.repeats = 5'(GATE_REPEATS);
                    n_gv         = 1'b1;
                    n_gval       = GATE_HARD;
                end
                if (n_st.gate == GATE_NONE && {1'b0, pk} > r_soft_thr) begin
                    n_st.gate    = GATE_SOFT;
                    n_st.repeats = 5'(GATE_REPEATS);
                    n_gv         = 1'b1;
                    n_gval       = GATE_SOFT;
                end
                if (ram_rdata.count < COUNT_MAX) n_st.count = ram_rdata.count + 4'd1;
            end
        end
    end

    assign ram_we    = (r_state == ST_CLEAR) || (r_state == ST_EVAL);
    assign ram_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_key[AW-1:0];
    assign ram_wdata = (r_state == ST_CLEAR) ? t_key_state'('0) : n_st;
    assign div_start = (r_state == ST_EVAL) && n_emit && (n_kind != EV_END);

    assign s_axis_tready = (r_state == ST_IDLE) && !r_res_valid;

    // signed result; quotient tops out at 2048, which 12 bits hold
    logic [12:0] n_roll_q, n_yaw_q;
    always_comb begin
        logic [12:0] rv, yv;
        rv = {1'b0, roll_quot};
        yv = {1'b0, yaw_quot};
        n_roll_q = (r_roll_win == '0) ? 13'd0 : (r_roll_neg ? 13'(-rv) : rv);
        n_yaw_q  = (r_yaw_win == '0) ? 13'd0 : (r_yaw_neg ? 13'(-yv) : yv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_res_valid <= 1'b0;
            r_soft_thr  <= 13'd100;
            r_hard_thr  <= 13'd800;
            r_roll_win  <= 13'd1024;
            r_yaw_win   <= 13'd1024;
            r_debounce  <= 20'd20000;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SOFT_THR: r_soft_thr <= i_cfg_data[12:0];
                    CFG_HARD_THR: r_hard_thr <= i_cfg_data[12:0];
                    CFG_ROLL_WIN: r_roll_win <= i_cfg_data[12:0];
                    CFG_YAW_WIN:  r_yaw_win  <= i_cfg_data[12:0];
                    CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) r_res_valid <= 1'b0;
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(KEY_COUNT - 1)) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_time     <= s_axis_tdata[47:0];
                        r_key      <= s_axis_tdata[55:48];
                        r_act      <= s_axis_tdata[56];
                        r_press    <= s_axis_tdata[68:57];
                        r_roll_raw <= s_axis_tdata[80:69];
                        r_yaw_raw  <= s_axis_tdata[92:81];
                        if ({24'd0, s_axis_tdata[55:48]} < 32'(KEY_COUNT)) r_state <= ST_READ;
                    end
                end
                ST_READ: r_state <= ST_EVAL;
                ST_EVAL: begin
                    r_res.event_kind   <= n_kind;
                    r_res.key_out      <= r_key;
                    r_res.pressure_out <= (n_kind == EV_END) ? 12'd0 : r_press;
                    r_res.roll_out     <= '0;
                    r_res.yaw_out      <= '0;
                    r_res.gate_valid   <= n_gv;
                    r_res.gate_value   <= n_gval;
                    r_roll_neg         <= n_roll_neg;
                    r_yaw_neg          <= n_yaw_neg;
                    if (!n_emit) r_state <= ST_IDLE;
                    else if (n_kind == EV_END) begin
                        r_res_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end else r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (roll_done && yaw_done) r_state <= ST_OUT;
                end
                ST_OUT: begin
                    r_res.roll_out <= n_roll_q;
                    r_res.yaw_out  <= n_yaw_q;
                    r_res_valid    <= 1'b1;
                    r_state        <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_res_valid;
    assign m_axis_tdata  = {5'd0, r_res};

    // no item taken while clearing
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !s_axis_tready)
        else $error("item accepted during clearing pass");
    // result register not overwritten while unread
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("pending result changed");
    // dividers finish together
    a_div_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        roll_done == yaw_done)
        else $error("dividers out of step");
endmodule

// ----- rtl/kvgt_ram.sv -----
module kvgt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/kvgt_div.sv -----
// Restoring divider for the window normalization: (mag*2048 + w/2) / w.
// Quotient is at most 2048 (12 bits), one bit per cycle.
module kvgt_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [11:0] i_mag,
    input  logic [12:0] i_win,
    output logic        o_done,
    output logic [11:0] o_quot
);
    localparam int NUM_W = 24;

    logic [NUM_W-1:0] r_num;
    logic [12:0]      r_win;
    logic [13:0]      r_rem;
    logic [11:0]      r_quot;
    logic [4:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [13:0]      n_trial;
    logic [13:0]      n_shift;

    assign n_shift = {r_rem[12:0], r_num[NUM_W-1]};
    assign n_trial = n_shift - {1'b0, r_win};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= {1'b0, i_mag, 11'd0} + {12'd0, i_win[12:1]};
                r_win  <= i_win;
                r_rem  <= '0;
                r_quot <= '0;
                r_cnt  <= 5'(NUM_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                if (!n_trial[13]) begin
                    r_rem  <= n_trial;
                    r_quot <= {r_quot[10:0], 1'b1};
                end else begin
                    r_rem  <= n_shift;
                    r_quot <= {r_quot[10:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
